### rtl/ppg_pkg.sv
package ppg_pkg;

    localparam int MASK_DEPTH    = 512;
    localparam int POSITION_BITS = 16;

    localparam int MASK_AW  = $clog2(MASK_DEPTH);
    localparam int MEM_DEPTH = 3 * MASK_DEPTH;
    localparam int MEM_AW   = $clog2(MEM_DEPTH);
    localparam int WIDE_W   = (POSITION_BITS > 16 ? POSITION_BITS : 16) + 1;
    localparam int LEN_W    = 10;
    localparam int COUNT_W  = 16;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int IN_DW    = 16;
    localparam int OUT_DW   = 16;
    localparam int IDX_W    = 9;

    typedef logic [CFG_AW-1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_TOTAL_LENGTH = cfg_addr_t'(0);
    localparam cfg_addr_t CFG_PRE_LEN      = cfg_addr_t'(1);
    localparam cfg_addr_t CFG_MAIN_LEN     = cfg_addr_t'(2);
    localparam cfg_addr_t CFG_POST_LEN     = cfg_addr_t'(3);
    localparam cfg_addr_t CFG_REPEAT_COUNT = cfg_addr_t'(4);

    typedef enum logic [1:0] {
        REGION_PRE  = 2'd0,
        REGION_MAIN = 2'd1,
        REGION_POST = 2'd2,
        REGION_NONE = 2'd3
    } region_t;

    typedef enum logic {
        FUNC_WRITE   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef struct packed {
        logic [POSITION_BITS-1:0] pos;
        logic                     last;
        region_t                  sel;
    } cls_t;

endpackage

### rtl/puncture_position_generator.sv
// an advance transaction passes the mask-read stage and then the output register before it shows on the master side
// throughput: one transaction per cycle, mask writes and advances alike, while the master side does not stall
// the mask memory has a single read port; an advance reads it at most once, and not at all outside the regions
// reset: counters and valid flags clear and config registers take their defaults; the mask memory is not cleared
module puncture_position_generator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  ppg_pkg::cfg_addr_t          cfg_addr,
    input  logic [ppg_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // mask_region [1:0], mask_index [10:2], mask_bit [11], zero [15:12]
    input  logic [ppg_pkg::IN_DW-1:0]   s_tdata,
    // func [0]
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // position [15:0]
    output logic [ppg_pkg::OUT_DW-1:0]  m_tdata,
    // punctured [0]
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int W = ppg_pkg::WIDE_W;

    logic                          s_accept, adv_accept, wr_accept, wr_ok;
    ppg_pkg::region_t              wr_region;
    logic [ppg_pkg::IDX_W-1:0]     wr_idx;
    logic [ppg_pkg::MASK_AW-1:0]   mask_idx;
    logic [ppg_pkg::MEM_AW-1:0]    wr_addr, rd_addr;
    logic                          wr_bit;
    ppg_pkg::cls_t                 cls;

    logic                          wr_en, rd_en, mask_data;

    logic                          s1_valid_reg;
    ppg_pkg::cls_t                 s1_cls_reg;
    logic                          s1_move, s1_kept;

    logic                          out_valid_reg;
    logic [ppg_pkg::OUT_DW-1:0]    out_pos_reg;
    logic                          out_punct_reg;
    logic                          out_last_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign adv_accept = s_accept && (ppg_pkg::func_t'(s_tuser) == ppg_pkg::FUNC_ADVANCE);
    assign wr_accept  = s_accept && (ppg_pkg::func_t'(s_tuser) == ppg_pkg::FUNC_WRITE);

    assign wr_region = ppg_pkg::region_t'(s_tdata[1:0]);
    assign wr_idx    = s_tdata[10:2];
    assign wr_bit    = s_tdata[11];
    assign wr_ok     = W'(wr_idx) < W'(ppg_pkg::MASK_DEPTH);

    // the three masks sit one after another in the mask memory
    assign wr_addr = ppg_pkg::MEM_AW'(wr_region) * ppg_pkg::MEM_AW'(ppg_pkg::MASK_DEPTH)
                     + ppg_pkg::MEM_AW'(wr_idx);
    assign rd_addr = ppg_pkg::MEM_AW'(cls.sel) * ppg_pkg::MEM_AW'(ppg_pkg::MASK_DEPTH)
                     + ppg_pkg::MEM_AW'(mask_idx);

    assign wr_en = wr_accept && wr_ok && (wr_region != ppg_pkg::REGION_NONE);
    assign rd_en = adv_accept && (cls.sel != ppg_pkg::REGION_NONE);

    ppg_classifier u_classifier
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .advance  (adv_accept),
        .cls      (cls),
        .rd_addr  (mask_idx)
    );

    ppg_mask_ram u_mask_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_bit),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mask_data)
    );

    // mask read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_accept)
        begin
            s1_cls_reg <= cls;
        end
    end

    always_comb
    begin
        unique case (s1_cls_reg.sel)
            ppg_pkg::REGION_PRE:  s1_kept = mask_data;
            ppg_pkg::REGION_MAIN: s1_kept = mask_data;
            ppg_pkg::REGION_POST: s1_kept = mask_data;
            ppg_pkg::REGION_NONE: s1_kept = 1'b1;
            default:              s1_kept = 1'b1;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pos_reg   <= ppg_pkg::OUT_DW'(s1_cls_reg.pos);
            out_punct_reg <= !s1_kept;
            out_last_reg  <= s1_cls_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pos_reg;
    assign m_tuser  = out_punct_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/ppg_mask_ram.sv
module ppg_mask_ram
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ppg_pkg::MEM_AW-1:0] wr_addr,
    input  logic                       wr_data,
    input  logic                       rd_en,
    input  logic [ppg_pkg::MEM_AW-1:0] rd_addr,
    output logic                       rd_data
);

    logic mem [ppg_pkg::MEM_DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ppg_classifier.sv
module ppg_classifier
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  ppg_pkg::cfg_addr_t           cfg_addr,
    input  logic [ppg_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                         advance,
    output ppg_pkg::cls_t                cls,
    output logic [ppg_pkg::MASK_AW-1:0]  rd_addr
);

    localparam int W = ppg_pkg::WIDE_W;

    logic [ppg_pkg::COUNT_W-1:0]       total_length_reg;
    logic [ppg_pkg::LEN_W-1:0]         pre_len_reg;
    logic [ppg_pkg::LEN_W-1:0]         main_len_reg;
    logic [ppg_pkg::LEN_W-1:0]         post_len_reg;
    logic [ppg_pkg::COUNT_W-1:0]       repeat_count_reg;

    logic [ppg_pkg::POSITION_BITS-1:0] pos_reg, pos_next;
    logic [ppg_pkg::LEN_W-1:0]         phase_reg, phase_next;
    logic [ppg_pkg::COUNT_W-1:0]       periods_reg, periods_next;

    logic [W-1:0]              pos_w, tot_w, post_start, idx;
    logic                      has_post, in_pre, in_post, in_main, last;
    logic [ppg_pkg::LEN_W-1:0] phase_inc;
    ppg_pkg::region_t          sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= ppg_pkg::COUNT_W'(1);
            pre_len_reg      <= '0;
            main_len_reg     <= ppg_pkg::LEN_W'(1);
            post_len_reg     <= '0;
            repeat_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ppg_pkg::CFG_TOTAL_LENGTH: total_length_reg <= cfg_data;
                ppg_pkg::CFG_PRE_LEN:      pre_len_reg      <= cfg_data[ppg_pkg::LEN_W-1:0];
                ppg_pkg::CFG_MAIN_LEN:     main_len_reg     <= cfg_data[ppg_pkg::LEN_W-1:0];
                ppg_pkg::CFG_POST_LEN:     post_len_reg     <= cfg_data[ppg_pkg::LEN_W-1:0];
                ppg_pkg::CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pos_w      = W'(pos_reg);
        tot_w      = W'(total_length_reg);
        has_post   = W'(post_len_reg) < tot_w;
        post_start = has_post ? tot_w - W'(post_len_reg) : '0;
        in_pre     = pos_w < W'(pre_len_reg);
        in_post    = has_post && (post_len_reg != '0) && (pos_w >= post_start);
        in_main    = has_post && (pos_w < post_start) && (main_len_reg != '0)
                     && ((repeat_count_reg == '0) || (periods_reg < repeat_count_reg));
        last       = (pos_w + W'(1)) >= tot_w;

        priority if (in_pre)
        begin
            sel = ppg_pkg::REGION_PRE;
            idx = pos_w;
        end
        else if (in_post)
        begin
            sel = ppg_pkg::REGION_POST;
            idx = pos_w - post_start;
        end
        else if (in_main)
        begin
            sel = ppg_pkg::REGION_MAIN;
            idx = W'(phase_reg);
        end
        else
        begin
            sel = ppg_pkg::REGION_NONE;
            idx = '0;
        end

        // entries beyond the mask depth read as kept
        if (idx >= W'(ppg_pkg::MASK_DEPTH))
        begin
            sel = ppg_pkg::REGION_NONE;
        end

        phase_inc    = phase_reg + ppg_pkg::LEN_W'(1);
        phase_next   = phase_reg;
        periods_next = periods_reg;
        if ((sel == ppg_pkg::REGION_MAIN) || (in_main && !in_pre && !in_post))
        begin
            if (phase_inc >= main_len_reg)
            begin
                phase_next = '0;
                if (periods_reg != '1)
                begin
                    periods_next = periods_reg + ppg_pkg::COUNT_W'(1);
                end
            end
            else
            begin
                phase_next = phase_inc;
            end
        end

        if (last)
        begin
            pos_next     = '0;
            phase_next   = '0;
            periods_next = '0;
        end
        else
        begin
            pos_next = pos_reg + ppg_pkg::POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= '0;
            periods_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            periods_reg <= periods_next;
        end
    end

    assign cls.pos  = pos_reg;
    assign cls.last = last;
    assign cls.sel  = sel;
    assign rd_addr  = ppg_pkg::MASK_AW'(idx);

endmodule
